// ----- hdl/mipo_pkg.sv -----
// mipo_pkg: shared types and constants for the mip chain image offset unit
// item structs, configuration register indexes, datapath widths
// no dependencies
`timescale 1ns / 1ps

package mipo_pkg;

    localparam int MAX_LEVELS = 13;
    localparam int MAX_DIM    = 4096;
    localparam int MAX_SLICES = 512;

    localparam int LEVEL_W = 4;
    localparam int FACE_W  = 9;
    localparam int DIM_W   = 13;
    localparam int DEPTH_W = 10;
    localparam int BPT_W   = 5;
    localparam int KIND_W  = 2;
    localparam int PITCH_W = 17;
    localparam int SIZE_W  = 40;
    localparam int FSZ_W   = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 13;
    localparam int PROD_W  = 40;

    localparam logic [PITCH_W-1:0] PITCH_ROUND = PITCH_W'(63);
    localparam logic [DEPTH_W-1:0] CUBE_FACES  = DEPTH_W'(6);
    localparam logic [BPT_W-1:0]   MAX_BPT     = BPT_W'(16);

    localparam logic [KIND_W-1:0] KIND_CUBE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_3D   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_KIND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DEPTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_TEXEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIP_TOP         = 3'd5;

    typedef struct packed {
        logic [FACE_W-1:0]  face_index;
        logic [LEVEL_W-1:0] level_index;
    } in_item_t;

    typedef struct packed {
        logic               valid_res;
        logic [SIZE_W-1:0]  img_offset;
        logic [PITCH_W-1:0] row_pitch;
        logic [DIM_W-1:0]   level_width;
        logic [DIM_W-1:0]   level_height;
        logic [DEPTH_W-1:0] level_depth;
        logic [SIZE_W-1:0]  tex_bytes;
    } out_item_t;

endpackage

// ----- hdl/mipo_mul.sv -----
// mipo_mul: shared multiplier with registered product
// depends on mipo_pkg for operand and product widths
`timescale 1ns / 1ps

module mipo_mul (
    input  logic                        clk,
    input  logic                        en,
    input  logic [mipo_pkg::MUL_A_W-1:0] a,
    input  logic [mipo_pkg::MUL_B_W-1:0] b,
    output logic [mipo_pkg::PROD_W-1:0]  prod
);

    logic [mipo_pkg::MUL_A_W+mipo_pkg::MUL_B_W-1:0] full;
    logic [mipo_pkg::PROD_W-1:0]                    prod_reg;

    assign full = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[mipo_pkg::PROD_W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/mip_chain_image_offset_unit.sv -----
// mip_chain_image_offset_unit: mip chain layout, image offset and total size per query
// depends on mipo_pkg and mipo_mul
//
//  port group   direction  handshake              payload
//  in           in         in_valid / in_ready    in_data   (mipo_pkg::in_item_t)
//  out          out        out_valid / out_ready  out_data  (mipo_pkg::out_item_t)
//  cfg          in         cfg_wen                cfg_index, cfg_data
//
// each item is computed step by step on one shared multiplier, in this order:
// pitch, one pitch * height step per level, face count and face index products
// in_ready is high whenever the sequencer is idle; a finished item waits in the output register
// the final step stalls only while the previous item still sits unread in the output register
// reset clears the configuration to its defaults and empties the output register
`timescale 1ns / 1ps

module mip_chain_image_offset_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mipo_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mipo_pkg::out_item_t                  out_data,
    input  logic                                 cfg_wen,
    input  logic [mipo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mipo_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PITCH = 8'b0000_0010,
        S_ALIGN = 8'b0000_0100,
        S_LEVEL = 8'b0000_1000,
        S_FLUSH = 8'b0001_0000,
        S_TOTAL = 8'b0010_0000,
        S_OFFS  = 8'b0100_0000,
        S_ADD   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [mipo_pkg::KIND_W-1:0]  kind_cfg_reg;
    logic [mipo_pkg::DIM_W-1:0]   width_cfg_reg;
    logic [mipo_pkg::DIM_W-1:0]   height_cfg_reg;
    logic [mipo_pkg::DEPTH_W-1:0] depth_cfg_reg;
    logic [mipo_pkg::BPT_W-1:0]   bpt_cfg_reg;
    logic [mipo_pkg::LEVEL_W-1:0] last_cfg_reg;

    // clamped configuration
    logic [mipo_pkg::DIM_W-1:0]   w_clamp, h_clamp;
    logic [mipo_pkg::DEPTH_W-1:0] d_clamp, faces_sel;
    logic [mipo_pkg::BPT_W-1:0]   bpt_clamp;
    logic [mipo_pkg::LEVEL_W-1:0] last_clamp;

    // working registers
    logic [mipo_pkg::FACE_W-1:0]  face_reg;
    logic [mipo_pkg::LEVEL_W-1:0] level_reg;
    logic [mipo_pkg::LEVEL_W-1:0] last_reg;
    logic [mipo_pkg::LEVEL_W-1:0] cnt_reg;
    logic [mipo_pkg::DEPTH_W-1:0] faces_reg;
    logic [mipo_pkg::BPT_W-1:0]   bpt_reg;
    logic [mipo_pkg::DIM_W-1:0]   w_reg, h_reg;
    logic [mipo_pkg::DEPTH_W-1:0] d_reg;
    logic [mipo_pkg::DIM_W-1:0]   lw_reg, lh_reg;
    logic [mipo_pkg::DEPTH_W-1:0] ld_reg;
    logic [mipo_pkg::PITCH_W-1:0] pitch_reg;
    logic [mipo_pkg::FSZ_W-1:0]   face_size_reg;
    logic [mipo_pkg::FSZ_W-1:0]   level_off_reg;
    logic [mipo_pkg::SIZE_W-1:0]  total_reg;
    logic                         pend_reg;
    logic [mipo_pkg::FSZ_W-1:0]   sum_now;

    logic                         out_valid_reg, out_valid_next;
    mipo_pkg::out_item_t          out_reg;
    mipo_pkg::out_item_t          result;
    logic                         hit;
    logic                         out_free;

    // shared multiplier
    logic                          mul_en;
    logic [mipo_pkg::MUL_A_W-1:0]  mul_a;
    logic [mipo_pkg::MUL_B_W-1:0]  mul_b;
    logic [mipo_pkg::PROD_W-1:0]   prod;

    mipo_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_cfg_reg   <= '0;
            width_cfg_reg  <= mipo_pkg::DIM_W'(1);
            height_cfg_reg <= mipo_pkg::DIM_W'(1);
            depth_cfg_reg  <= mipo_pkg::DEPTH_W'(1);
            bpt_cfg_reg    <= mipo_pkg::BPT_W'(4);
            last_cfg_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                mipo_pkg::REG_TARGET_KIND:     kind_cfg_reg   <= cfg_data[mipo_pkg::KIND_W-1:0];
                mipo_pkg::REG_BASE_WIDTH:      width_cfg_reg  <= cfg_data[mipo_pkg::DIM_W-1:0];
                mipo_pkg::REG_BASE_HEIGHT:     height_cfg_reg <= cfg_data[mipo_pkg::DIM_W-1:0];
                mipo_pkg::REG_BASE_DEPTH:      depth_cfg_reg  <= cfg_data[mipo_pkg::DEPTH_W-1:0];
                mipo_pkg::REG_BYTES_PER_TEXEL: bpt_cfg_reg    <= cfg_data[mipo_pkg::BPT_W-1:0];
                mipo_pkg::REG_MIP_TOP:         last_cfg_reg   <= cfg_data[mipo_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_cfg_reg == '0)
            w_clamp = mipo_pkg::DIM_W'(1);
        else if (width_cfg_reg > mipo_pkg::DIM_W'(mipo_pkg::MAX_DIM))
            w_clamp = mipo_pkg::DIM_W'(mipo_pkg::MAX_DIM);
        else
            w_clamp = width_cfg_reg;

        if (height_cfg_reg == '0)
            h_clamp = mipo_pkg::DIM_W'(1);
        else if (height_cfg_reg > mipo_pkg::DIM_W'(mipo_pkg::MAX_DIM))
            h_clamp = mipo_pkg::DIM_W'(mipo_pkg::MAX_DIM);
        else
            h_clamp = height_cfg_reg;

        if (depth_cfg_reg == '0)
            d_clamp = mipo_pkg::DEPTH_W'(1);
        else if (depth_cfg_reg > mipo_pkg::DEPTH_W'(mipo_pkg::MAX_SLICES))
            d_clamp = mipo_pkg::DEPTH_W'(mipo_pkg::MAX_SLICES);
        else
            d_clamp = depth_cfg_reg;

        if (bpt_cfg_reg == '0)
            bpt_clamp = mipo_pkg::BPT_W'(1);
        else if (bpt_cfg_reg > mipo_pkg::MAX_BPT)
            bpt_clamp = mipo_pkg::MAX_BPT;
        else
            bpt_clamp = bpt_cfg_reg;

        if (last_cfg_reg > mipo_pkg::LEVEL_W'(mipo_pkg::MAX_LEVELS - 1))
            last_clamp = mipo_pkg::LEVEL_W'(mipo_pkg::MAX_LEVELS - 1);
        else
            last_clamp = last_cfg_reg;

        case (kind_cfg_reg)
            mipo_pkg::KIND_CUBE: faces_sel = mipo_pkg::CUBE_FACES;
            mipo_pkg::KIND_3D:   faces_sel = d_clamp;
            default:             faces_sel = mipo_pkg::DEPTH_W'(1);
        endcase
    end

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_PITCH:
            begin
                mul_en = 1'b1;
                mul_a  = mipo_pkg::MUL_A_W'(w_reg);
                mul_b  = mipo_pkg::MUL_B_W'(bpt_reg);
            end
            S_LEVEL:
            begin
                mul_en = 1'b1;
                mul_a  = mipo_pkg::MUL_A_W'(pitch_reg);
                mul_b  = h_reg;
            end
            S_TOTAL:
            begin
                mul_en = 1'b1;
                mul_a  = face_size_reg;
                mul_b  = mipo_pkg::MUL_B_W'(faces_reg);
            end
            S_OFFS:
            begin
                mul_en = 1'b1;
                mul_a  = face_size_reg;
                mul_b  = mipo_pkg::MUL_B_W'(face_reg);
            end
            default: ;
        endcase
    end

    // running face size with the product still in flight
    assign sum_now = face_size_reg + (pend_reg ? prod[mipo_pkg::FSZ_W-1:0] : '0);

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PITCH;
            S_PITCH: state_next = S_ALIGN;
            S_ALIGN: state_next = S_LEVEL;
            S_LEVEL: if (cnt_reg == last_reg) state_next = S_FLUSH;
            S_FLUSH: state_next = S_TOTAL;
            S_TOTAL: state_next = S_OFFS;
            S_OFFS:  state_next = S_ADD;
            S_ADD:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign hit = ({1'b0, face_reg} < faces_reg) && (level_reg <= last_reg);

    always_comb
    begin
        result = '0;
        if (hit)
        begin
            result.valid_res    = 1'b1;
            result.img_offset   = prod + mipo_pkg::SIZE_W'(level_off_reg);
            result.row_pitch    = pitch_reg;
            result.level_width  = lw_reg;
            result.level_height = lh_reg;
            result.level_depth  = ld_reg;
            result.tex_bytes    = total_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (state_reg == S_ADD && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    pend_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                S_LEVEL:
                begin
                    pend_reg <= 1'b1;
                    if (cnt_reg != last_reg)
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_FLUSH: pend_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    face_reg      <= in_data.face_index;
                    level_reg     <= in_data.level_index;
                    last_reg      <= last_clamp;
                    faces_reg     <= faces_sel;
                    bpt_reg       <= bpt_clamp;
                    w_reg         <= w_clamp;
                    h_reg         <= h_clamp;
                    d_reg         <= d_clamp;
                    face_size_reg <= '0;
                    level_off_reg <= '0;
                    lw_reg        <= '0;
                    lh_reg        <= '0;
                    ld_reg        <= '0;
                end
            end
            S_ALIGN:
            begin
                pitch_reg <= (prod[mipo_pkg::PITCH_W-1:0] + mipo_pkg::PITCH_ROUND)
                             & ~mipo_pkg::PITCH_ROUND;
            end
            S_LEVEL:
            begin
                if (cnt_reg == level_reg)
                begin
                    level_off_reg <= sum_now;
                    lw_reg        <= w_reg;
                    lh_reg        <= h_reg;
                    ld_reg        <= d_reg;
                end
                face_size_reg <= sum_now;
                w_reg <= (w_reg[mipo_pkg::DIM_W-1:1] == '0) ? mipo_pkg::DIM_W'(1)
                                                            : (w_reg >> 1);
                h_reg <= (h_reg[mipo_pkg::DIM_W-1:1] == '0) ? mipo_pkg::DIM_W'(1)
                                                            : (h_reg >> 1);
                d_reg <= (d_reg[mipo_pkg::DEPTH_W-1:1] == '0) ? mipo_pkg::DEPTH_W'(1)
                                                              : (d_reg >> 1);
            end
            S_FLUSH: face_size_reg <= sum_now;
            S_OFFS:  total_reg     <= prod;
            S_ADD:
            begin
                if (out_free)
                    out_reg <= result;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
